// File: rtl/cvoi_pkg.sv
// shared types and constants for the odometry integrator
package cvoi_pkg;

	localparam logic [1:0] FUNC_CMD  = 2'd0;
	localparam logic [1:0] FUNC_GOAL = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;
	localparam logic [1:0] FUNC_NOP  = 2'd3;

	localparam logic [2:0] REG_MAX_X       = 3'd0;
	localparam logic [2:0] REG_MAX_Y       = 3'd1;
	localparam logic [2:0] REG_MAX_TURN    = 3'd2;
	localparam logic [2:0] REG_PERIOD      = 3'd3;
	localparam logic [2:0] REG_START_HEAD  = 3'd4;
	localparam logic [2:0] REG_START_X     = 3'd5;
	localparam logic [2:0] REG_START_Y     = 3'd6;
	localparam logic [2:0] REG_START_TURN  = 3'd7;

	localparam logic [17:0] SIN_A = 18'd102944;
	localparam logic [17:0] SIN_B = 18'd42048;
	localparam logic [17:0] SIN_C = 18'd4640;

	// one step of the controller's multiply sequence
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SIN,
		ST_COS,
		ST_RX1,
		ST_RX2,
		ST_RY1,
		ST_RY2,
		ST_DX,
		ST_DY,
		ST_DTH,
		ST_COMMIT,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    load_item;
		logic    apply_simple;
		state_t  step;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic    is_tick;
		logic    poly_done;
	} dp_status_t;

endpackage

// File: rtl/cvoi_ctrl.sv
// sequencer for the odometry integrator
module cvoi_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_fire,
	input  logic                  out_free,
	input  cvoi_pkg::dp_status_t  status,
	output cvoi_pkg::dp_cmd_t     cmd,
	output logic                  busy
);

	cvoi_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= cvoi_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d          = state_q;
		cmd.load_item    = 1'b0;
		cmd.apply_simple = 1'b0;
		cmd.step         = state_q;
		busy             = (state_q != cvoi_pkg::ST_IDLE);
		case (state_q)
			cvoi_pkg::ST_IDLE: begin
				if (in_fire) begin
					cmd.load_item = 1'b1;
					state_d = cvoi_pkg::ST_SIN;
				end
			end
			cvoi_pkg::ST_SIN: begin
				if (!status.is_tick) begin
					cmd.apply_simple = 1'b1;
					state_d = cvoi_pkg::ST_OUT;
				end else if (status.poly_done) state_d = cvoi_pkg::ST_COS;
			end
			cvoi_pkg::ST_COS:    if (status.poly_done) state_d = cvoi_pkg::ST_RX1;
			cvoi_pkg::ST_RX1:    state_d = cvoi_pkg::ST_RX2;
			cvoi_pkg::ST_RX2:    state_d = cvoi_pkg::ST_RY1;
			cvoi_pkg::ST_RY1:    state_d = cvoi_pkg::ST_RY2;
			cvoi_pkg::ST_RY2:    state_d = cvoi_pkg::ST_DX;
			cvoi_pkg::ST_DX:     state_d = cvoi_pkg::ST_DY;
			cvoi_pkg::ST_DY:     state_d = cvoi_pkg::ST_DTH;
			cvoi_pkg::ST_DTH:    state_d = cvoi_pkg::ST_COMMIT;
			cvoi_pkg::ST_COMMIT: state_d = cvoi_pkg::ST_OUT;
			cvoi_pkg::ST_OUT:    if (out_free) state_d = cvoi_pkg::ST_IDLE;
			default:             state_d = cvoi_pkg::ST_IDLE;
		endcase
	end

endmodule

// File: rtl/cvoi_datapath.sv
// state registers, sine polynomial and tick multiply datapath
module cvoi_datapath #(
	parameter int ANGLE_BITS = 16,
	parameter int POS_BITS   = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cvoi_pkg::dp_cmd_t           cmd,
	output cvoi_pkg::dp_status_t        status,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_idx,
	input  logic [31:0]                 cfg_data,
	input  logic [1:0]                  func,
	input  logic signed [31:0]          cmd_speed_x,
	input  logic signed [31:0]          cmd_speed_y,
	input  logic signed [23:0]          cmd_turn_rate,
	input  logic                        goal_reached,
	output logic signed [POS_BITS-1:0]  position_x,
	output logic signed [POS_BITS-1:0]  position_y,
	output logic [ANGLE_BITS-1:0]       heading_angle,
	output logic signed [31:0]          velocity_x,
	output logic signed [31:0]          velocity_y,
	output logic signed [23:0]          angular_rate,
	output logic                        goal_stop
);

	logic [30:0] max_x_q, max_y_q;
	logic [22:0] max_turn_q;
	logic [15:0] period_q;

	logic signed [POS_BITS-1:0] pos_x_q, pos_y_q;
	logic [ANGLE_BITS-1:0]      head_q;
	logic signed [31:0]         vx_q, vy_q;
	logic signed [23:0]         wr_q;
	logic                       stop_q;

	// latched item
	logic [1:0]          func_q;
	logic signed [31:0]  cx_q, cy_q;
	logic signed [23:0]  cw_q;
	logic                goal_q;

	// sine polynomial sub-sequencer
	logic [2:0]          pstep_q;
	logic [16:0]         z_q;
	logic [17:0]         z2_q, t_q;
	logic                neg_q;
	logic signed [17:0]  sin_q, cos_q;
	logic signed [49:0]  acc_q;
	logic signed [49:0]  rx_q, ry_q;
	// position step can exceed the 32-bit range before saturation
	logic signed [49:0]  dx_q, dy_q;
	logic signed [41:0]  dth_full;

	// quadrant setup for sine or cosine
	logic [31:0] phase;
	logic [1:0]  quad;
	logic [29:0] frac;
	logic [30:0] g;
	always_comb begin
		phase = {head_q, {(32-ANGLE_BITS){1'b0}}}
			+ ((cmd.step == cvoi_pkg::ST_COS) ? 32'h4000_0000 : 32'd0);
		quad  = phase[31:30];
		frac  = phase[29:0];
		g     = quad[0] ? (31'h4000_0000 - {1'b0, frac}) : {1'b0, frac};
	end

	// one 18x18 unsigned product per polynomial step
	logic [35:0] pprod;
	logic [17:0] pa, pb;
	always_comb begin
		pa = z2_q;
		pb = t_q;
		case (pstep_q)
			3'd1: begin pa = {1'b0, z_q}; pb = {1'b0, z_q}; end
			3'd2: begin pa = z2_q; pb = cvoi_pkg::SIN_C; end
			3'd3: begin pa = z2_q; pb = t_q; end
			3'd4: begin pa = {1'b0, z_q}; pb = t_q; end
			default: begin pa = z2_q; pb = t_q; end
		endcase
		pprod = 36'(pa) * 36'(pb);
	end

	// signed 32x18 products for the rotation
	logic signed [31:0] mv;
	logic signed [17:0] mt;
	logic signed [49:0] mprod;
	always_comb begin
		case (cmd.step)
			cvoi_pkg::ST_RX1: begin mv = vx_q; mt = cos_q; end
			cvoi_pkg::ST_RX2: begin mv = vy_q; mt = sin_q; end
			cvoi_pkg::ST_RY1: begin mv = vx_q; mt = sin_q; end
			default:          begin mv = vy_q; mt = cos_q; end
		endcase
		mprod = 50'(mv) * 50'(mt);
	end

	// rotated velocity times period
	logic signed [49:0] rsel;
	logic signed [66:0] dprod;
	always_comb begin
		rsel  = (cmd.step == cvoi_pkg::ST_DX) ? rx_q : ry_q;
		dprod = 67'(rsel) * 67'($signed({1'b0, period_q}));
	end

	assign dth_full = 42'(wr_q) * 42'($signed({1'b0, period_q}));

	function automatic logic signed [POS_BITS-1:0] sat_add(
		input logic signed [POS_BITS-1:0] a,
		input logic signed [49:0] b
	);
		logic signed [50:0] s, hi, lo;
		hi = {{(52-POS_BITS){1'b0}}, {(POS_BITS-1){1'b1}}};
		lo = {{(52-POS_BITS){1'b1}}, {(POS_BITS-1){1'b0}}};
		s  = 51'(a) + 51'(b);
		if (s > hi)
			sat_add = hi[POS_BITS-1:0];
		else if (s < lo)
			sat_add = lo[POS_BITS-1:0];
		else
			sat_add = s[POS_BITS-1:0];
	endfunction

	function automatic logic signed [31:0] clamp32(
		input logic signed [31:0] v,
		input logic [30:0] lim
	);
		logic signed [32:0] l;
		l = {2'b00, lim};
		if ($signed({v[31], v}) > l) clamp32 = l[31:0];
		else if ($signed({v[31], v}) < -l) clamp32 = 32'(-l);
		else clamp32 = v;
	endfunction

	logic signed [24:0] wl;
	logic signed [23:0] wclamp;
	always_comb begin
		wl = {2'b00, max_turn_q};
		if ($signed({cw_q[23], cw_q}) > wl) wclamp = wl[23:0];
		else if ($signed({cw_q[23], cw_q}) < -wl) wclamp = 24'(-wl);
		else wclamp = cw_q;
	end

	logic signed [49:0] dsx, dsy;
	assign dsx = 50'(dprod >>> 16);
	assign dsy = 50'(dprod >>> 16);

	logic poly_busy;
	assign poly_busy = (cmd.step == cvoi_pkg::ST_SIN) || (cmd.step == cvoi_pkg::ST_COS);
	assign status.poly_done = (pstep_q == 3'd5);
	assign status.is_tick   = (func_q == cvoi_pkg::FUNC_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q    <= 31'd65536;
			max_y_q    <= 31'd65536;
			max_turn_q <= 23'd16384;
			period_q   <= 16'd6554;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			head_q     <= '0;
			vx_q       <= '0;
			vy_q       <= '0;
			wr_q       <= '0;
			stop_q     <= 1'b0;
			pstep_q    <= '0;
			func_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					cvoi_pkg::REG_MAX_X:      max_x_q <= cfg_data[30:0];
					cvoi_pkg::REG_MAX_Y:      max_y_q <= cfg_data[30:0];
					cvoi_pkg::REG_MAX_TURN:   max_turn_q <= cfg_data[22:0];
					cvoi_pkg::REG_PERIOD:     period_q <= cfg_data[15:0];
					cvoi_pkg::REG_START_HEAD: head_q <= ANGLE_BITS'(cfg_data[15:0]);
					cvoi_pkg::REG_START_X:    vx_q <= cfg_data;
					cvoi_pkg::REG_START_Y:    vy_q <= cfg_data;
					cvoi_pkg::REG_START_TURN: wr_q <= cfg_data[23:0];
					default: ;
				endcase
			end
			if (cmd.load_item) func_q <= func;
			if (cmd.apply_simple) begin
				if (func_q == cvoi_pkg::FUNC_CMD) begin
					if (stop_q) begin
						vx_q <= '0; vy_q <= '0; wr_q <= '0;
					end else begin
						vx_q <= clamp32(cx_q, max_x_q);
						vy_q <= clamp32(cy_q, max_y_q);
						wr_q <= wclamp;
					end
				end else if (func_q == cvoi_pkg::FUNC_GOAL) begin
					stop_q <= goal_q;
				end
			end
			if (poly_busy && status.is_tick) begin
				if (pstep_q == 3'd5) pstep_q <= '0;
				else pstep_q <= pstep_q + 3'd1;
			end
			if (cmd.step == cvoi_pkg::ST_COMMIT) begin
				pos_x_q <= sat_add(pos_x_q, dx_q);
				pos_y_q <= sat_add(pos_y_q, dy_q);
				head_q  <= head_q + ANGLE_BITS'(dth_full >>> (32 - ANGLE_BITS));
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cx_q <= cmd_speed_x; cy_q <= cmd_speed_y;
			cw_q <= cmd_turn_rate; goal_q <= goal_reached;
		end
		if (poly_busy) begin
			case (pstep_q)
				3'd0: begin z_q <= g[30:14]; neg_q <= quad[1]; end
				3'd1: z2_q <= pprod[33:16];
				3'd2: t_q <= cvoi_pkg::SIN_B - pprod[33:16];
				3'd3: t_q <= cvoi_pkg::SIN_A - pprod[33:16];
				3'd4: t_q <= pprod[33:16];
				3'd5: begin
					if (cmd.step == cvoi_pkg::ST_SIN)
						sin_q <= neg_q ? -$signed(t_q) : $signed(t_q);
					else
						cos_q <= neg_q ? -$signed(t_q) : $signed(t_q);
				end
				default: ;
			endcase
		end
		case (cmd.step)
			cvoi_pkg::ST_RX1: acc_q <= mprod;
			cvoi_pkg::ST_RX2: rx_q <= (acc_q - mprod) >>> 16;
			cvoi_pkg::ST_RY1: acc_q <= mprod;
			cvoi_pkg::ST_RY2: ry_q <= (acc_q + mprod) >>> 16;
			cvoi_pkg::ST_DX:  dx_q <= dsx;
			cvoi_pkg::ST_DY:  dy_q <= dsy;
			default: ;
		endcase
	end

	assign position_x    = pos_x_q;
	assign position_y    = pos_y_q;
	assign heading_angle = head_q;
	assign velocity_x    = vx_q;
	assign velocity_y    = vy_q;
	assign angular_rate  = wr_q;
	assign goal_stop     = stop_q;

endmodule

// File: rtl/clamped_velocity_odometry_integrator.sv
// top level of the clamped velocity odometry integrator
//
// channel  dir  handshake              payload
// s_axis   in   s_axis_tvalid/tready   tdata: speeds and turn rate, tuser: func, goal
// m_axis   out  m_axis_tvalid/tready   tdata: pose, velocity, stop flag
// cfg      in   cfg_we                 cfg_idx, cfg_data
//
// command, goal and unused events are applied in ST_SIN and go on to ST_OUT
// a tick runs two 6-step sine polynomial passes on one
// 18x18 multiplier, four rotation products, two period products, a heading
// step, commit, then the load into the output register
// one item in the sequencer at a time; a finished pose moves to the output
// register, so the next item is accepted while a result waits to be taken
// a full output register under stall holds the sequencer in ST_OUT
// reset loads the start registers' reset values; a start write loads state
module clamped_velocity_odometry_integrator #(
	parameter int ANGLE_BITS = 16,
	parameter int POS_BITS   = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// cmd_speed_x[31:0], cmd_speed_y[63:32], cmd_turn_rate[87:64]
	input  logic [87:0]  s_axis_tdata,
	// func[1:0], goal_reached[2]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// pos_x[31:0], pos_y[63:32], heading[79:64], speed_x[111:80],
	// speed_y[143:112], turn_rate[167:144], stopped[168], zero pad
	output logic [175:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [31:0]  cfg_data
);

	cvoi_pkg::dp_cmd_t    cmd;
	cvoi_pkg::dp_status_t status;
	logic busy;
	logic in_fire;
	logic out_free;
	logic result_load;

	logic signed [POS_BITS-1:0] position_x, position_y;
	logic [ANGLE_BITS-1:0]      heading_angle;
	logic signed [31:0]         velocity_x, velocity_y;
	logic signed [23:0]         angular_rate;
	logic                       goal_stop;

	logic [175:0] out_data_q;
	logic         out_valid_q;

	// input taken only when idle
	assign s_axis_tready = !busy;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// output register can take a new pose when empty or being drained
	assign out_free    = !out_valid_q || m_axis_tready;
	assign result_load = (cmd.step == cvoi_pkg::ST_OUT) && out_free;

	cvoi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	cvoi_datapath #(
		.ANGLE_BITS (ANGLE_BITS),
		.POS_BITS   (POS_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.func          (s_axis_tuser[1:0]),
		.cmd_speed_x   (s_axis_tdata[31:0]),
		.cmd_speed_y   (s_axis_tdata[63:32]),
		.cmd_turn_rate (s_axis_tdata[87:64]),
		.goal_reached  (s_axis_tuser[2]),
		.position_x    (position_x),
		.position_y    (position_y),
		.heading_angle (heading_angle),
		.velocity_x    (velocity_x),
		.velocity_y    (velocity_y),
		.angular_rate  (angular_rate),
		.goal_stop     (goal_stop)
	);

	// output register, loaded from the state registers in ST_OUT
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (result_load) begin
				out_valid_q <= 1'b1;
				out_data_q  <= {7'd0, goal_stop, angular_rate, velocity_y, velocity_x,
					16'(heading_angle), 32'(position_y), 32'(position_x)};
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// no item taken while the sequencer works on one
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (cmd.step == cvoi_pkg::ST_IDLE))
		else $error("input ready while sequencer busy");

	// a non-tick item reaches ST_OUT by way of ST_SIN after accept
	a_short_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (s_axis_tuser[1:0] != cvoi_pkg::FUNC_TICK))
		|=> ##1 (cmd.step == cvoi_pkg::ST_OUT))
		else $error("short item latency wrong");

	// a result held under stall keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result changed under stall");

endmodule

// File: dv/clamped_velocity_odometry_integrator_tb.sv
// self-checking testbench for the clamped velocity odometry integrator
`timescale 1ns / 1ps

module clamped_velocity_odometry_integrator_tb;

	// one event going in
	typedef struct {
		logic [1:0]         func;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [23:0] wz;
		logic               goal;
	} event_t;

	// one pose report coming out
	typedef struct packed {
		logic [6:0]         pad;
		logic               stopped;
		logic signed [23:0] turn_rate;
		logic signed [31:0] speed_y;
		logic signed [31:0] speed_x;
		logic [15:0]        heading;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_x;
	} pose_t;

	// directed row: the event, and a typed-in pose where one is obvious
	typedef struct {
		event_t ev;
		logic   known;
		pose_t  pose;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [87:0]  s_axis_tdata;
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [175:0] m_axis_tdata;
	logic         cfg_we;
	logic [2:0]   cfg_idx;
	logic [31:0]  cfg_data;

	clamped_velocity_odometry_integrator DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// predictor copy of the registers and the odometry state
	logic [30:0]        lim_x, lim_y;
	logic [22:0]        lim_turn;
	logic [15:0]        period;
	logic signed [63:0] odo_x, odo_y;
	logic [15:0]        odo_head;
	logic signed [63:0] vel_x, vel_y, rate;
	logic               odo_stop;

	pose_t pose_queue[$];
	int    errors;
	int    mismatches;
	bit    sink_hold;

	// quarter-wave sine polynomial, g in 0..2^30, result 0..65536
	function automatic logic signed [63:0] quarter_wave(logic [31:0] g);
		logic [63:0] z, z2, t;
		z  = g >> 14;
		z2 = (z * z) >> 16;
		t  = (z2 * 64'd4640) >> 16;
		t  = 64'd42048 - t;
		t  = (z2 * t) >> 16;
		t  = 64'd102944 - t;
		return $signed((z * t) >> 16);
	endfunction

	function automatic logic signed [63:0] phase_sine(logic [31:0] p);
		logic [31:0]        f;
		logic signed [63:0] s;
		f = p & 32'h3fff_ffff;
		s = p[30] ? quarter_wave(32'h4000_0000 - f) : quarter_wave(f);
		return p[31] ? -s : s;
	endfunction

	function automatic logic signed [63:0] clamp_pos(logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic signed [63:0] clamp_to(logic signed [63:0] v,
			logic signed [63:0] lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// >>> on signed 64-bit values is a floor shift
	function automatic void integrate_tick();
		logic [31:0]        p;
		logic signed [63:0] s, c, rx, ry, dt, dth;
		p   = {odo_head, 16'h0};
		s   = phase_sine(p);
		c   = phase_sine(p + 32'h4000_0000);
		dt  = $signed({48'h0, period});
		rx  = (vel_x * c - vel_y * s) >>> 16;
		ry  = (vel_x * s + vel_y * c) >>> 16;
		dth = (rate * dt) >>> 16;
		odo_x    = clamp_pos(odo_x + ((rx * dt) >>> 16));
		odo_y    = clamp_pos(odo_y + ((ry * dt) >>> 16));
		odo_head = odo_head + dth[15:0];
	endfunction

	function automatic pose_t next_pose(event_t ev);
		pose_t r;
		case (ev.func)
			cvoi_pkg::FUNC_CMD: begin
				if (odo_stop) begin
					vel_x = 0;
					vel_y = 0;
					rate  = 0;
				end else begin
					vel_x = clamp_to(ev.vx, $signed({33'h0, lim_x}));
					vel_y = clamp_to(ev.vy, $signed({33'h0, lim_y}));
					rate  = clamp_to(ev.wz, $signed({41'h0, lim_turn}));
				end
			end
			cvoi_pkg::FUNC_GOAL: odo_stop = ev.goal;
			cvoi_pkg::FUNC_TICK: integrate_tick();
			default: ;
		endcase
		r           = '0;
		r.pos_x     = odo_x[31:0];
		r.pos_y     = odo_y[31:0];
		r.heading   = odo_head;
		r.speed_x   = vel_x[31:0];
		r.speed_y   = vel_y[31:0];
		r.turn_rate = rate[23:0];
		r.stopped   = odo_stop;
		return r;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			cvoi_pkg::REG_MAX_X:      lim_x    = value[30:0];
			cvoi_pkg::REG_MAX_Y:      lim_y    = value[30:0];
			cvoi_pkg::REG_MAX_TURN:   lim_turn = value[22:0];
			cvoi_pkg::REG_PERIOD:     period   = value[15:0];
			cvoi_pkg::REG_START_HEAD: odo_head = value[15:0];
			cvoi_pkg::REG_START_X:    vel_x    = $signed(value);
			cvoi_pkg::REG_START_Y:    vel_y    = $signed(value);
			cvoi_pkg::REG_START_TURN: rate     = $signed(value[23:0]);
			default: ;
		endcase
	endtask

	// hold off until the block is drained, plus the tick latency
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pose_queue.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic send_event(event_t ev, logic known, pose_t typed);
		pose_t p;
		int    idle;
		idle = $urandom_range(0, 15);
		if (idle != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		p = next_pose(ev);
		if (known && p != typed) begin
			errors++;
			if (mismatches++ < 10)
				$display("directed row disagrees: table %h predictor %h", typed, p);
		end
		pose_queue.insert(pose_queue.size(), p);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {ev.wz, ev.vy, ev.vx};
		s_axis_tuser  <= {ev.goal, ev.func};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	function automatic event_t random_event();
		event_t e;
		int     k;
		k      = $urandom_range(0, 99);
		e.func = k < 45 ? cvoi_pkg::FUNC_TICK : k < 80 ? cvoi_pkg::FUNC_CMD
			: k < 95 ? cvoi_pkg::FUNC_GOAL : cvoi_pkg::FUNC_NOP;
		e.goal = $urandom_range(0, 3) == 0;
		case ($urandom_range(0, 3))
			0: begin
				e.vx = $urandom;
				e.vy = $urandom;
				e.wz = 24'($urandom);
			end
			default: begin
				// mostly speeds near the limits so the pose moves visibly
				e.vx = $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
				e.vy = $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
				e.wz = 24'($signed($urandom_range(0, 24'h00_c000)) - 24'sh00_6000);
			end
		endcase
		return e;
	endfunction

	// sink: random stall per item, compare against oldest prediction
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (pose_queue.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected item %h", m_axis_tdata);
			end else begin
				pose_t want;
				want = pose_queue.pop_front();
				if (m_axis_tdata !== want) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: expected %h actual %h", want, m_axis_tdata);
				end
			end
		end
	end

	initial begin
		int stall;
		m_axis_tready = 1'b0;
		sink_hold     = 1'b0;
		stall         = 0;
		forever begin
			@(posedge clk);
			if (sink_hold) begin
				m_axis_tready <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				stall = $urandom_range(0, 15);
				m_axis_tready <= stall == 0;
			end else if (stall > 0) begin
				stall--;
				m_axis_tready <= stall == 0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// limit: over a thousand items with random idle and stall gaps, taken many times over
	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end

	row_t rows[$];

	function automatic void add_row(row_t r);
		rows.insert(rows.size(), r);
	endfunction

	function automatic row_t mk(logic [1:0] f, logic signed [31:0] vx,
			logic signed [31:0] vy, logic signed [23:0] wz, logic g);
		row_t r;
		r.ev    = '{f, vx, vy, wz, g};
		r.known = 1'b0;
		r.pose  = '0;
		return r;
	endfunction

	function automatic row_t mk_known(row_t r, logic signed [31:0] sx,
			logic signed [31:0] sy, logic signed [23:0] tr, logic st);
		r.known          = 1'b1;
		r.pose           = '0;
		r.pose.speed_x   = sx;
		r.pose.speed_y   = sy;
		r.pose.turn_rate = tr;
		r.pose.stopped   = st;
		return r;
	endfunction

	task automatic run_random(int n);
		pose_t none;
		none = '0;
		for (int i = 0; i < n; i++)
			send_event(random_event(), 1'b0, none);
	endtask

	initial begin
		errors        = 0;
		mismatches    = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		cfg_we        = 1'b0;
		cfg_idx       = '0;
		cfg_data      = '0;
		lim_x    = 31'd65536;
		lim_y    = 31'd65536;
		lim_turn = 23'd16384;
		period   = 16'd6554;
		odo_x    = 0;
		odo_y    = 0;
		odo_head = 0;
		vel_x    = 0;
		vel_y    = 0;
		rate     = 0;
		odo_stop = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: state right after reset, clamping at extremes, stop mode
		add_row(mk_known(mk(cvoi_pkg::FUNC_NOP, 0, 0, 0, 0), 0, 0, 0, 0));
		add_row(mk_known(mk(cvoi_pkg::FUNC_TICK, 0, 0, 0, 0), 0, 0, 0, 0));
		add_row(mk_known(mk(cvoi_pkg::FUNC_CMD, 32'h7fff_ffff, 32'h8000_0000,
			24'h7f_ffff, 0), 65536, -65536, 16384, 0));
		add_row(mk_known(mk(cvoi_pkg::FUNC_CMD, 32'h8000_0000, 32'h7fff_ffff,
			24'h80_0000, 0), -65536, 65536, -16384, 0));
		add_row(mk(cvoi_pkg::FUNC_TICK, 0, 0, 0, 0));
		add_row(mk(cvoi_pkg::FUNC_CMD, 1000, -2000, 300, 1));
		add_row(mk(cvoi_pkg::FUNC_TICK, 0, 0, 0, 0));
		add_row(mk(cvoi_pkg::FUNC_TICK, 0, 0, 0, 0));
		add_row(mk(cvoi_pkg::FUNC_GOAL, -1, -1, -1, 1));
		add_row(mk_known(mk(cvoi_pkg::FUNC_CMD, 5000, 5000, 100, 0), 0, 0, 0, 1));
		add_row(mk(cvoi_pkg::FUNC_GOAL, 0, 0, 0, 0));
		add_row(mk(cvoi_pkg::FUNC_CMD, -1, 32'hffff_0000, -1, 1));
		add_row(mk(cvoi_pkg::FUNC_TICK, 0, 0, 0, 0));
		add_row(mk(cvoi_pkg::FUNC_NOP, -1, -1, -1, 1));
		foreach (rows[i]) begin
			// position and heading of known rows follow from prior rows
			if (rows[i].known) begin
				rows[i].pose.pos_x   = odo_x[31:0];
				rows[i].pose.pos_y   = odo_y[31:0];
				rows[i].pose.heading = odo_head;
			end
			send_event(rows[i].ev, rows[i].known, rows[i].pose);
		end
		drain();

		// settings: zero limits and period, then extremes with saturating position
		write_reg(cvoi_pkg::REG_MAX_X, 32'h0);
		write_reg(cvoi_pkg::REG_MAX_Y, 32'h0);
		write_reg(cvoi_pkg::REG_MAX_TURN, 32'h0);
		write_reg(cvoi_pkg::REG_PERIOD, 32'h0);
		write_reg(cvoi_pkg::REG_START_HEAD, 32'hffff);
		write_reg(cvoi_pkg::REG_START_X, 32'h8000_0000);
		write_reg(cvoi_pkg::REG_START_Y, 32'h7fff_ffff);
		write_reg(cvoi_pkg::REG_START_TURN, 32'h0080_0000);
		run_random(150);
		drain();

		write_reg(cvoi_pkg::REG_MAX_X, 32'h7fff_ffff);
		write_reg(cvoi_pkg::REG_MAX_Y, 32'h7fff_ffff);
		write_reg(cvoi_pkg::REG_MAX_TURN, 32'h007f_ffff);
		write_reg(cvoi_pkg::REG_PERIOD, 32'hffff);
		write_reg(cvoi_pkg::REG_START_X, 32'h7fff_ffff);
		write_reg(cvoi_pkg::REG_START_Y, 32'h8000_0000);
		write_reg(cvoi_pkg::REG_START_TURN, 32'h007f_ffff);
		begin
			event_t t;
			pose_t  none;
			t    = '{cvoi_pkg::FUNC_TICK, 0, 0, 0, 0};
			none = '0;
			for (int i = 0; i < 40; i++)
				send_event(t, 1'b0, none);
		end
		run_random(250);

		// sender waits for all results, sink never stalls meanwhile
		sink_hold = 1'b1;
		drain();
		sink_hold = 1'b0;

		write_reg(cvoi_pkg::REG_MAX_X, $urandom_range(0, 32'h0004_0000));
		write_reg(cvoi_pkg::REG_MAX_Y, $urandom_range(0, 32'h0004_0000));
		write_reg(cvoi_pkg::REG_MAX_TURN, $urandom_range(0, 32'h0000_8000));
		write_reg(cvoi_pkg::REG_PERIOD, $urandom);
		write_reg(cvoi_pkg::REG_START_HEAD, $urandom);
		write_reg(cvoi_pkg::REG_START_X, $urandom);
		write_reg(cvoi_pkg::REG_START_Y, $urandom);
		write_reg(cvoi_pkg::REG_START_TURN, $urandom);
		run_random(600);
		drain();

		write_reg(cvoi_pkg::REG_MAX_X, 32'd65536);
		write_reg(cvoi_pkg::REG_MAX_Y, 32'd65536);
		write_reg(cvoi_pkg::REG_MAX_TURN, 32'd16384);
		write_reg(cvoi_pkg::REG_PERIOD, 32'd6554);
		write_reg(cvoi_pkg::REG_START_HEAD, 32'h4000);
		run_random(600);

		drain();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
